// File: hw/rtl/ihex_pkg.sv
`timescale 1ns / 1ps

package ihex_pkg;

  localparam int unsigned ImageBytesDefault = 1048576;
  localparam logic [31:0] ImageBaseReset = 32'h0100_0000;
  localparam int unsigned QueueDepth = 2;

  localparam int unsigned IndexWidth = 20;
  localparam int unsigned PosWidth = 10;
  localparam logic [PosWidth-1:0] PosMax = '1;

  localparam logic [7:0] CharNewline = 8'h0A;
  localparam logic [7:0] CharReturn = 8'h0D;
  localparam logic [7:0] CharColon = 8'h3A;

  localparam logic [7:0] RecData = 8'd0;
  localparam logic [7:0] RecExtLinear = 8'd4;

  typedef struct packed {
    logic        ok;
    logic [3:0]  value;
  } digit_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [7:0]  data;
  } wr_req_t;

  function automatic digit_t hex_digit(input logic [7:0] c);
    digit_t r;
    r.ok = 1'b1;
    r.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.value = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r.value = 4'(c[2:0] + 3'd1) + 4'd8;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  function automatic digit_t dec_digit(input logic [7:0] c);
    digit_t r;
    r.ok = (c >= 8'h30 && c <= 8'h39);
    r.value = r.ok ? c[3:0] : 4'd0;
    return r;
  endfunction

endpackage

// File: hw/rtl/ihex_front.sv
`timescale 1ns / 1ps

module ihex_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             char_valid_i,
  output logic             char_ready_o,
  input  logic [7:0]       char_i,
  output logic             push_o,
  output ihex_pkg::wr_req_t push_req_o,
  input  logic             queue_full_i
);
  import ihex_pkg::*;

  logic                line_valid_q, line_valid_d;
  logic [PosWidth-1:0] pos_q, pos_d;
  logic [3:0]          high_nibble_q, high_nibble_d;
  logic                pair_bad_q, pair_bad_d;
  logic [7:0]          byte_count_q, byte_count_d;
  logic [7:0]          record_type_q, record_type_d;
  logic [15:0]         record_address_q, record_address_d;
  logic [15:0]         extended_offset_q, extended_offset_d;

  logic                accept;
  logic                emit;
  digit_t              hd;
  digit_t              dd;
  logic [PosWidth-1:0] k;
  logic [PosWidth-2:0] item;
  logic [15:0]         acc_base;
  logic                acc_bad;
  logic [15:0]         acc_next;
  logic [16:0]         low_sum;

  assign char_ready_o = !queue_full_i;
  assign accept = char_valid_i && char_ready_o;
  assign hd = hex_digit(char_i);
  assign dd = dec_digit(char_i);
  assign k = pos_q - PosWidth'(9);
  assign item = k[PosWidth-1:1];

  always_comb begin
    line_valid_d = line_valid_q;
    pos_d = pos_q;
    high_nibble_d = high_nibble_q;
    pair_bad_d = pair_bad_q;
    byte_count_d = byte_count_q;
    record_type_d = record_type_q;
    record_address_d = record_address_q;
    extended_offset_d = extended_offset_q;
    emit = 1'b0;
    acc_base = record_address_q;
    acc_bad = pair_bad_q;
    if (pos_q == PosWidth'(3) || pos_q == PosWidth'(9)) begin
      acc_base = 16'd0;
      acc_bad = 1'b0;
    end
    acc_bad = acc_bad | !hd.ok;
    acc_next = {acc_base[11:0], hd.value};

    if (accept) begin
      priority if (char_i == CharNewline) begin
        pos_d = '0;
        line_valid_d = 1'b0;
        pair_bad_d = 1'b0;
      end else if (char_i == CharReturn) begin
        pos_d = pos_q;
      end else begin
        if (pos_q != PosMax) begin
          pos_d = pos_q + PosWidth'(1);
        end
        priority if (pos_q == '0) begin
          line_valid_d = (char_i == CharColon);
        end else if (!line_valid_q) begin
          pos_d = pos_d;
        end else if (pos_q == PosWidth'(1)) begin
          high_nibble_d = hd.value;
          pair_bad_d = !hd.ok;
        end else if (pos_q == PosWidth'(2)) begin
          byte_count_d = (pair_bad_q || !hd.ok) ? 8'd0 : {high_nibble_q, hd.value};
        end else if (pos_q <= PosWidth'(6)) begin
          pair_bad_d = acc_bad;
          record_address_d = (pos_q == PosWidth'(6) && acc_bad) ? 16'd0 : acc_next;
        end else if (pos_q == PosWidth'(7)) begin
          high_nibble_d = dd.value;
          pair_bad_d = !dd.ok;
        end else if (pos_q == PosWidth'(8)) begin
          record_type_d = (pair_bad_q || !dd.ok) ? 8'd0
                        : 8'(high_nibble_q) * 8'd10 + 8'(dd.value);
        end else if (record_type_q == RecData) begin
          if (!k[0]) begin
            high_nibble_d = hd.value;
            pair_bad_d = !hd.ok;
          end else if ({1'b0, item} < PosWidth'(byte_count_q)) begin
            emit = 1'b1;
          end
        end else if (record_type_q == RecExtLinear && pos_q <= PosWidth'(12)) begin
          pair_bad_d = acc_bad;
          record_address_d = acc_next;
          if (pos_q == PosWidth'(12)) begin
            extended_offset_d = acc_bad ? 16'd0 : acc_next;
          end
        end else begin
          emit = 1'b0;
        end
      end
    end
  end

  assign low_sum = 17'(record_address_q) + 17'(item);
  assign push_o = emit;
  assign push_req_o.addr = {extended_offset_q + 16'(low_sum[16]), low_sum[15:0]};
  assign push_req_o.data = (pair_bad_q || !hd.ok) ? 8'd0 : {high_nibble_q, hd.value};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_valid_q <= 1'b0;
      pos_q <= '0;
      high_nibble_q <= '0;
      pair_bad_q <= 1'b0;
      byte_count_q <= '0;
      record_type_q <= '0;
      record_address_q <= '0;
      extended_offset_q <= '0;
    end else begin
      line_valid_q <= line_valid_d;
      pos_q <= pos_d;
      high_nibble_q <= high_nibble_d;
      pair_bad_q <= pair_bad_d;
      byte_count_q <= byte_count_d;
      record_type_q <= record_type_d;
      record_address_q <= record_address_d;
      extended_offset_q <= extended_offset_d;
    end
  end

endmodule

// File: hw/rtl/ihex_queue.sv
`timescale 1ns / 1ps

module ihex_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ihex_pkg::wr_req_t push_req_i,
  output logic              full_o,
  output logic              valid_o,
  output ihex_pkg::wr_req_t head_o,
  input  logic              pop_i
);
  import ihex_pkg::*;

  localparam int unsigned PtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntWidth = $clog2(QueueDepth + 1);

  wr_req_t               mem_q [QueueDepth];
  logic [PtrWidth-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0]   count_q, count_d;
  logic                  do_pop;

  assign full_o = (count_q == CntWidth'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign head_o = mem_q[rd_ptr_q];
  assign do_pop = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrWidth'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrWidth'(1);
    end
    if (push_i && !do_pop) begin
      count_d = count_q + CntWidth'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - CntWidth'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

endmodule

// File: hw/rtl/ihex_back.sv
`timescale 1ns / 1ps

module ihex_back #(
  parameter int unsigned ImageBytes = ihex_pkg::ImageBytesDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [31:0]                    cfg_wdata_i,
  input  logic                           req_valid_i,
  input  ihex_pkg::wr_req_t              req_i,
  output logic                           req_pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ihex_pkg::IndexWidth-1:0] write_index_o,
  output logic [7:0]                     write_byte_o,
  output logic                           out_of_range_o
);
  import ihex_pkg::*;

  logic [31:0]           image_base_q;
  logic                  out_valid_q;
  logic [IndexWidth-1:0] write_index_q;
  logic [7:0]            write_byte_q;
  logic                  out_of_range_q;
  logic [31:0]           idx;
  logic                  oor;

  assign req_pop_o = req_valid_i && (!out_valid_q || out_ready_i);
  assign idx = req_i.addr - image_base_q;
  assign oor = (idx >= 32'(ImageBytes));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_base_q <= ImageBaseReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        image_base_q <= cfg_wdata_i;
      end
      if (req_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_pop_o) begin
      write_index_q <= oor ? '0 : idx[IndexWidth-1:0];
      write_byte_q <= req_i.data;
      out_of_range_q <= oor;
    end
  end

  assign out_valid_o = out_valid_q;
  assign write_index_o = write_index_q;
  assign write_byte_o = write_byte_q;
  assign out_of_range_o = out_of_range_q;

endmodule

// File: hw/rtl/intel_hex_record_loader.sv
`timescale 1ns / 1ps

// Loads an Intel hex text stream, one character per word, and produces one image write per
// data byte of each type 0 record, with the byte index formed from the extended linear offset,
// the record address and the image base register. The input takes one character per cycle;
// a data record yields at most one write per two characters. The parser feeds a two-entry
// queue in front of the registered output stage, so the input stalls only when both queue
// entries are held by a stalled output. Writes whose index is not below the image size are
// still delivered, with index zero and the out-of-range flag set.

module intel_hex_record_loader #(
  parameter int unsigned ImageBytes = ihex_pkg::ImageBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // text_char [7:0]
  input  logic [7:0]  s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // write_index [19:0], write_byte [27:20], out_of_range [28], zero [31:29]
  output logic [31:0] m_axis_tdata
);
  import ihex_pkg::*;

  logic                  push;
  wr_req_t               push_req;
  logic                  queue_full;
  logic                  queue_valid;
  wr_req_t               head;
  logic                  pop;
  logic [IndexWidth-1:0] write_index;
  logic [7:0]            write_byte;
  logic                  out_of_range;

  ihex_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_valid_i (s_axis_tvalid),
    .char_ready_o (s_axis_tready),
    .char_i       (s_axis_tdata),
    .push_o       (push),
    .push_req_o   (push_req),
    .queue_full_i (queue_full)
  );

  ihex_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_req_i (push_req),
    .full_o     (queue_full),
    .valid_o    (queue_valid),
    .head_o     (head),
    .pop_i      (pop)
  );

  ihex_back #(
    .ImageBytes (ImageBytes)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .req_valid_i    (queue_valid),
    .req_i          (head),
    .req_pop_o      (pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .write_index_o  (write_index),
    .write_byte_o   (write_byte),
    .out_of_range_o (out_of_range)
  );

  assign m_axis_tdata = {3'b000, out_of_range, write_byte, write_index};

endmodule

// File: tb/ihex_write_checker.sv
`timescale 1ns / 1ps

module ihex_write_checker #(
  parameter int unsigned ImageBytes = ihex_pkg::ImageBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  output int unsigned pending_writes,
  output int unsigned mismatches
);
  import ihex_pkg::*;

  typedef struct packed {
    logic        out_of_range;
    logic [7:0]  write_byte;
    logic [19:0] write_index;
  } image_write_t;

  image_write_t expected_writes[$];
  int unsigned  error_count;

  logic          line_ok;
  logic [9:0]    pos;
  logic [3:0]    hi_nib;
  logic          bad_pair;
  logic [7:0]    count;
  logic [7:0]    rtype;
  logic [15:0]   addr_acc;
  logic [15:0]   ext_off;
  logic [31:0]   base;

  // Bit 4 set means the character is not a hex digit.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
    if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h37);
    if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h57);
    return 5'd16;
  endfunction

  task automatic decode_char(input logic [7:0] c);
    logic [9:0]   p;
    logic [9:0]   k;
    logic [8:0]   slot;
    logic [4:0]   d;
    logic [4:0]   dv;
    logic [31:0]  idx;
    image_write_t w;
    if (c == CharNewline) begin
      pos = '0;
      line_ok = 1'b0;
      bad_pair = 1'b0;
    end else if (c != CharReturn) begin
      p = pos;
      if (p != PosMax) pos = p + 10'd1;
      d = hex_val(c);
      dv = (c >= 8'h30 && c <= 8'h39) ? {1'b0, c[3:0]} : 5'd16;
      if (p == 0) begin
        line_ok = (c == CharColon);
      end else if (line_ok) begin
        if (p == 1) begin
          hi_nib = d[3:0];
          bad_pair = d[4];
        end else if (p == 2) begin
          count = (bad_pair || d[4]) ? 8'd0 : {hi_nib, d[3:0]};
        end else if (p <= 6) begin
          if (p == 3) begin
            addr_acc = '0;
            bad_pair = 1'b0;
          end
          if (d[4]) bad_pair = 1'b1;
          addr_acc = {addr_acc[11:0], d[3:0]};
          if (p == 6 && bad_pair) addr_acc = '0;
        end else if (p <= 8) begin
          if (p == 7) begin
            hi_nib = dv[3:0];
            bad_pair = dv[4];
          end else begin
            rtype = (bad_pair || dv[4]) ? 8'd0 : 8'(hi_nib * 10 + dv[3:0]);
          end
        end else if (rtype == RecData) begin
          k = p - 10'd9;
          slot = k[9:1];
          if (!k[0]) begin
            hi_nib = d[3:0];
            bad_pair = d[4];
          end else if (slot < 9'(count)) begin
            idx = {ext_off, 16'h0000} + 32'(addr_acc) + 32'(slot) - base;
            w.out_of_range = (idx >= 32'(ImageBytes));
            w.write_index = w.out_of_range ? 20'd0 : idx[19:0];
            w.write_byte = (bad_pair || d[4]) ? 8'd0 : {hi_nib, d[3:0]};
            expected_writes.push_back(w);
          end
        end else if (rtype == RecExtLinear && p <= 12) begin
          if (p == 9) begin
            addr_acc = '0;
            bad_pair = 1'b0;
          end
          if (d[4]) bad_pair = 1'b1;
          addr_acc = {addr_acc[11:0], d[3:0]};
          if (p == 12) ext_off = bad_pair ? 16'd0 : addr_acc;
        end
      end
    end
  endtask

  task automatic check_write(input logic [31:0] word);
    image_write_t got;
    image_write_t want;
    got = word[28:0];
    if (expected_writes.size() == 0) begin
      $error("unexpected write word %h", word);
      error_count++;
    end else begin
      want = expected_writes.pop_front();
      if (got.write_index !== want.write_index) begin
        $error("write_index expected %h actual %h", want.write_index, got.write_index);
        error_count++;
      end
      if (got.write_byte !== want.write_byte) begin
        $error("write_byte expected %h actual %h", want.write_byte, got.write_byte);
        error_count++;
      end
      if (got.out_of_range !== want.out_of_range) begin
        $error("out_of_range expected %b actual %b", want.out_of_range, got.out_of_range);
        error_count++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_writes.delete();
      line_ok = 1'b0;
      pos = '0;
      hi_nib = '0;
      bad_pair = 1'b0;
      count = '0;
      rtype = '0;
      addr_acc = '0;
      ext_off = '0;
      base = ImageBaseReset;
      error_count = 0;
    end else begin
      if (cfg_we_i) base = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) decode_char(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) check_write(m_axis_tdata);
    end
    pending_writes <= expected_writes.size();
    mismatches <= error_count;
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import ihex_pkg::*;

  typedef enum int unsigned {
    FlipChar, Truncate, InsertReturn, DropColon, JunkLine, BadDigit
  } line_fault_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  int unsigned pending_writes;
  int unsigned mismatches;

  bit          quiet = 1'b0;
  int unsigned gap_pct = 25;
  int unsigned stall_pct = 20;
  int unsigned chars_sent = 0;
  logic [31:0] image_base_now = ImageBaseReset;
  logic [7:0]  line_buf[$];

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  intel_hex_record_loader DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  ihex_write_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pending_writes(pending_writes),
    .mismatches    (mismatches)
  );

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 10) return 8'h30 + 8'(v);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v - 10);
  endfunction

  task automatic add_hex(input logic [15:0] v, input int digits);
    for (int n = digits - 1; n >= 0; n--) line_buf.push_back(hex_char(v[n*4 +: 4]));
  endtask

  task automatic add_dec2(input int unsigned v);
    line_buf.push_back(8'h30 + 8'(v / 10));
    line_buf.push_back(8'h30 + 8'(v % 10));
  endtask

  task automatic add_str(input string s);
    for (int n = 0; n < s.len(); n++) line_buf.push_back(s[n]);
  endtask

  task automatic send_char(input logic [7:0] c);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= c;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    chars_sent++;
  endtask

  task automatic send_line();
    foreach (line_buf[n]) send_char(line_buf[n]);
    line_buf.delete();
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_writes != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_base(input logic [31:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    image_base_now = v;
  endtask

  // Mostly well-formed records whose offsets land near the image, with faults mixed in.
  task automatic send_random_line();
    int unsigned pick;
    int unsigned count;
    int unsigned rtype;
    int unsigned at;
    logic [7:0]  b;
    logic [15:0] offset;
    line_fault_e fault;
    pick = $urandom_range(0, 99);
    line_buf.push_back(CharColon);
    if (pick < 20) begin
      if ($urandom_range(0, 3) == 0) offset = 16'($urandom);
      else offset = image_base_now[31:16] + 16'($urandom_range(0, 16));
      add_hex(16'd2, 2);
      add_hex(16'($urandom), 4);
      add_dec2(4);
      add_hex(offset, 4);
    end else begin
      if (pick < 80) begin
        rtype = 0;
        count = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
      end else begin
        rtype = (pick < 90) ? ((pick % 4 == 3) ? 5 : pick % 4 + 1) : $urandom_range(0, 99);
        count = $urandom_range(0, 6);
      end
      add_hex(16'(count), 2);
      add_hex(16'($urandom), 4);
      add_dec2(rtype);
      repeat (count) add_hex(16'($urandom_range(0, 255)), 2);
    end
    add_hex(16'($urandom_range(0, 255)), 2);
    if ($urandom_range(0, 3) == 0) line_buf.push_back(CharReturn);
    line_buf.push_back(CharNewline);
    if ($urandom_range(0, 99) < 30) begin
      fault = line_fault_e'($urandom_range(0, 5));
      case (fault)
        FlipChar: begin
          line_buf[$urandom_range(0, line_buf.size() - 2)] = 8'($urandom_range(0, 255));
        end
        Truncate: begin
          at = $urandom_range(1, line_buf.size() - 1);
          while (line_buf.size() > at) void'(line_buf.pop_back());
          line_buf.push_back(CharNewline);
        end
        InsertReturn: begin
          line_buf.insert($urandom_range(0, line_buf.size() - 1), CharReturn);
        end
        DropColon: begin
          b = 8'($urandom_range(0, 255));
          line_buf[0] = (b == CharColon) ? 8'h2E : b;
        end
        JunkLine: begin
          line_buf.delete();
          repeat ($urandom_range(1, 20)) begin
            b = 8'($urandom_range(0, 255));
            line_buf.push_back((b == CharNewline) ? 8'h20 : b);
          end
          line_buf.push_back(CharNewline);
        end
        BadDigit: begin
          pick = $urandom_range(0, 4);
          b = (pick == 0) ? 8'h47 : (pick == 1) ? 8'h7A : (pick == 2) ? 8'h41 :
              (pick == 3) ? 8'h66 : 8'h20;
          line_buf[$urandom_range(1, 8)] = b;
        end
        default: begin
        end
      endcase
    end
    send_line();
  endtask

  // A full 255-byte record that crosses a 64K page, followed by 520 trailing characters
  // mixed from colons, hex digits, returns and random bytes.
  task automatic send_long_line();
    int unsigned pick;
    logic [7:0]  b;
    add_str(":02000004");
    add_hex(image_base_now[31:16] , 4);
    add_str("F8");
    line_buf.push_back(CharNewline);
    add_str(":FFFF8000");
    repeat (255) add_hex(16'($urandom_range(0, 255)), 2);
    repeat (520) begin
      pick = $urandom_range(0, 3);
      b = 8'($urandom_range(0, 255));
      if (b == CharNewline) b = 8'h20;
      line_buf.push_back((pick == 0) ? CharColon : (pick == 1) ? hex_char(4'(b)) :
                         (pick == 2) ? CharReturn : b);
    end
    line_buf.push_back(CharNewline);
    send_line();
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 7)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    logic [31:0] bases[5];
    int unsigned goal;
    bases[0] = ImageBaseReset;
    bases[1] = 32'h0000_0000;
    bases[2] = 32'hFFFF_FFFF;
    bases[3] = $urandom;
    bases[4] = 32'h00F8_0000;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    line_buf.push_back(8'h00);
    line_buf.push_back(8'hFF);
    line_buf.push_back(CharNewline);
    add_str(":020000040100");
    line_buf.push_back(CharNewline);
    add_str(":010000007f");
    line_buf.push_back(CharReturn);
    line_buf.push_back(CharNewline);
    send_line();
    send_long_line();

    goal = chars_sent;
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        drain();
        write_base(bases[ph]);
      end
      case (ph)
        0: begin gap_pct = 25; stall_pct = 20; end
        1: begin gap_pct = 0;  stall_pct = 0;  end
        2: begin gap_pct = 60; stall_pct = 50; end
        3: begin gap_pct = 10; stall_pct = 35; end
        default: quiet = 1'b1;
      endcase
      goal += 85;
      while (chars_sent < goal) send_random_line();
    end

    drain();
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("tb failed");
    $finish;
  end

endmodule
